### src/lst_pkg.sv
// ----------------------------------------------------------------------------
// lst_pkg - latency statistics tracker shared definitions
// Widths, word types and stage records used across the tracker files.
// ----------------------------------------------------------------------------
package lst_pkg;

    localparam int LAT_W   = 30;              // latency / average / min / max
    localparam int CNT_W   = 16;              // sample count and target
    localparam int VAR_W   = 32;              // variance estimate
    localparam int ERR_W   = 30;              // signed error, |err| <= 2^29
    localparam int PROD_W  = 2 * ERR_W;       // full signed product
    localparam int SQ_W    = 2 * ERR_W - 2;   // err^2 < 2^58
    localparam int SUM_W   = SQ_W + 1;        // var + err^2

    // Words in flight: skid (2) + front stage + square stage + result.
    localparam int PIPE_WORDS = 5;
    localparam int OUTST_W    = $clog2(PIPE_WORDS + 1);

    typedef logic [LAT_W-1:0]        t_lat;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [VAR_W-1:0]        t_var;
    typedef logic signed [ERR_W-1:0] t_err;
    typedef logic [SQ_W-1:0]         t_sq;

    localparam t_lat LAT_ONES = '1;

    typedef struct packed {
        logic edge_seen;
        t_lat latency_ns;
    } t_in_word;

    // Record handed from the front (count/avg/min/max) stage to the back end.
    typedef struct packed {
        logic done_res;
        logic sample;
        t_cnt count;
        t_lat avg_ns;
        t_lat min_ns;
        t_lat max_ns;
        t_err err;
    } t_front_word;

    typedef struct packed {
        logic done_res;
        logic rearm;
        t_cnt sample_count;
        t_lat average_ns;
        t_var variance_est;
        t_lat minimum_ns;
        t_lat maximum_ns;
    } t_result;

endpackage

### src/lst_if.sv
// ----------------------------------------------------------------------------
// lst_if - tracker channel interfaces
// Valid/ready channels for tick words in and statistics words out.
// ----------------------------------------------------------------------------
interface lst_in_if;
    logic           valid;
    logic           ready;
    logic           edge_seen;
    lst_pkg::t_lat  latency_ns;

    modport source (output valid, edge_seen, latency_ns, input ready);
    modport sink   (input valid, edge_seen, latency_ns, output ready);
endinterface

interface lst_out_if;
    logic           valid;
    logic           ready;
    logic           done_res;
    logic           rearm;
    lst_pkg::t_cnt  sample_count;
    lst_pkg::t_lat  average_ns;
    lst_pkg::t_var  variance_est;
    lst_pkg::t_lat  minimum_ns;
    lst_pkg::t_lat  maximum_ns;

    modport source (output valid, done_res, rearm, sample_count, average_ns,
                    variance_est, minimum_ns, maximum_ns, input ready);
    modport sink   (input valid, done_res, rearm, sample_count, average_ns,
                    variance_est, minimum_ns, maximum_ns, output ready);
endinterface

### src/lst_skid.sv
// ----------------------------------------------------------------------------
// lst_skid - input register with skid slot
// Two-entry buffer; ready toward the source comes straight from a flop.
// ----------------------------------------------------------------------------
module lst_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lst_in_if.sink            i_in,
    input  logic              i_ready,
    output logic              o_valid,
    output lst_pkg::t_in_word o_word
);

    logic              r_main_valid;
    logic              r_skid_valid;
    lst_pkg::t_in_word r_main;
    lst_pkg::t_in_word r_skid;
    lst_pkg::t_in_word in_word;
    logic              acc;
    logic              load;

    assign in_word.edge_seen  = i_in.edge_seen;
    assign in_word.latency_ns = i_in.latency_ns;

    assign i_in.ready = !r_skid_valid;
    assign acc        = i_in.valid && !r_skid_valid;
    assign load       = !r_main_valid || i_ready;   // main slot empty or leaving

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (load) begin
            r_main_valid <= r_skid_valid || acc;
            r_skid_valid <= 1'b0;
        end else if (acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_main <= r_skid_valid ? r_skid : in_word;
        end
        if (!load && acc) begin
            r_skid <= in_word;
        end
    end

    assign o_valid = r_main_valid;
    assign o_word  = r_main;

endmodule

### src/lst_front.sv
// ----------------------------------------------------------------------------
// lst_front - count, average, min and max update
// Holds the target and the running state; emits the halved error for squaring.
// ----------------------------------------------------------------------------
module lst_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  lst_pkg::t_cnt        i_cfg_wr_data,
    input  logic                 i_valid,
    input  lst_pkg::t_in_word    i_word,
    input  logic                 i_adv,
    output logic                 o_valid,
    output lst_pkg::t_front_word o_word
);

    lst_pkg::t_cnt        r_target;
    lst_pkg::t_cnt        r_count;
    lst_pkg::t_lat        r_avg;
    lst_pkg::t_lat        r_min;
    lst_pkg::t_lat        r_max;
    logic                 r_valid;
    lst_pkg::t_front_word r_word;

    logic                   done;
    logic                   take;
    lst_pkg::t_lat          s;
    logic [lst_pkg::LAT_W:0] avg_sum;
    logic [lst_pkg::LAT_W:0] diff;
    lst_pkg::t_cnt          n_count;
    lst_pkg::t_lat          n_avg;
    lst_pkg::t_lat          n_min;
    lst_pkg::t_lat          n_max;
    lst_pkg::t_err          n_err;
    lst_pkg::t_front_word   n_word;

    always_comb begin
        s       = i_word.latency_ns;
        done    = (r_count == r_target);
        take    = i_valid && i_adv && !done && i_word.edge_seen;
        avg_sum = {1'b0, s} + {1'b0, r_avg};
        diff    = {1'b0, r_avg} - {1'b0, s};
        n_count = r_count + lst_pkg::t_cnt'(1);
        // Empty average takes the sample as is; error is then zero.
        n_avg   = (r_avg == '0) ? s : avg_sum[lst_pkg::LAT_W:1];
        // new_avg - s == floor((avg - s) / 2)
        n_err   = (r_avg == '0) ? '0 : $signed(diff[lst_pkg::LAT_W:1]);
        n_min   = (s < r_min) ? s : r_min;
        n_max   = (s > r_max) ? s : r_max;

        n_word.done_res = done;
        n_word.sample   = take;
        n_word.count    = take ? n_count : r_count;
        n_word.avg_ns   = take ? n_avg   : r_avg;
        n_word.min_ns   = take ? n_min   : r_min;
        n_word.max_ns   = take ? n_max   : r_max;
        n_word.err      = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_count  <= '0;
            r_avg    <= '0;
            r_min    <= lst_pkg::LAT_ONES;
            r_max    <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_target <= i_cfg_wr_data;
            end
            if (take) begin
                r_count <= n_count;
                r_avg   <= n_avg;
                r_min   <= n_min;
                r_max   <= n_max;
            end
            if (i_adv) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

### src/lst_back.sv
// ----------------------------------------------------------------------------
// lst_back - error square, variance update and result register
// One multiply stage, then the halving variance add into the result word.
// ----------------------------------------------------------------------------
module lst_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  lst_pkg::t_front_word i_word,
    output logic                 o_valid,
    output lst_pkg::t_result     o_res
);

    logic                    r_p2_valid;
    lst_pkg::t_front_word    r_p2_word;
    lst_pkg::t_sq            r_sq;
    lst_pkg::t_var           r_var;
    logic                    r_res_valid;
    lst_pkg::t_result        r_res;

    logic signed [lst_pkg::PROD_W-1:0] prod;
    logic [lst_pkg::SUM_W-1:0]         var_sum;
    lst_pkg::t_var                     n_var;
    logic                              var_upd;
    lst_pkg::t_result                  n_res;

    always_comb begin
        prod    = i_word.err * i_word.err;
        var_sum = lst_pkg::SUM_W'(r_var) + lst_pkg::SUM_W'(r_sq);
        var_upd = r_p2_valid && r_p2_word.sample;
        n_var   = var_upd ? var_sum[lst_pkg::VAR_W:1] : r_var;

        n_res.done_res     = r_p2_word.done_res;
        n_res.rearm        = !r_p2_word.done_res;
        n_res.sample_count = r_p2_word.count;
        n_res.average_ns   = r_p2_word.avg_ns;
        n_res.variance_est = n_var;
        n_res.minimum_ns   = r_p2_word.min_ns;
        n_res.maximum_ns   = r_p2_word.max_ns;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid  <= 1'b0;
            r_res_valid <= 1'b0;
            r_var       <= '0;
        end else if (i_adv) begin
            r_p2_valid  <= i_valid;
            r_res_valid <= r_p2_valid;
            r_var       <= n_var;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_p2_word <= i_word;
            r_sq      <= prod[lst_pkg::SQ_W-1:0];
            r_res     <= n_res;
        end
    end

    assign o_valid = r_res_valid;
    assign o_res   = r_res;

endmodule

### src/latency_statistics_tracker.sv
// ----------------------------------------------------------------------------
// latency_statistics_tracker - running latency statistics
// Per tick: sample count, halving average, halving variance, min and max.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          word
//  --------  ---  -----------------  ----------------------------------------
//  i_in      in   valid/ready        edge_seen, latency_ns
//  o_out     out  valid/ready        done_res, rearm, sample_count, average_ns,
//                                    variance_est, minimum_ns, maximum_ns
//  i_cfg_*   in   write enable only  sample_target (16 bit)
//
//  One word per cycle while o_out.ready stays high; a result passes through
//  the skid register, the count/avg/min/max stage, the square stage and the
//  variance add into the result register.
//  Reset (i_rst_n low, synchronous) empties the pipe and restores the
//  statistics: count, average, variance and max to zero, min to all ones.
//  A stalled output freezes every stage; the skid slot still takes one more
//  word, so i_in.ready is a flop and never waits on o_out.ready directly.
//
module latency_statistics_tracker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  lst_pkg::t_cnt i_cfg_wr_data,
    lst_in_if.sink        i_in,
    lst_out_if.source     o_out
);

    // Pipe advance: the result slot is free or being taken this cycle.
    logic                 adv;
    logic                 skid_valid;
    lst_pkg::t_in_word    skid_word;
    logic                 front_valid;
    lst_pkg::t_front_word front_word;
    logic                 res_valid;
    lst_pkg::t_result     res;

    assign adv = !res_valid || o_out.ready;

    // Input register with one spare slot.
    lst_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ready (adv),
        .o_valid (skid_valid),
        .o_word  (skid_word)
    );

    // Done check against the target; count/avg/min/max update; halved error.
    lst_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (skid_valid),
        .i_word        (skid_word),
        .i_adv         (adv),
        .o_valid       (front_valid),
        .o_word        (front_word)
    );

    // err^2 register, then (var + err^2) / 2 into the result word.
    lst_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (front_valid),
        .i_word  (front_word),
        .o_valid (res_valid),
        .o_res   (res)
    );

    assign o_out.valid        = res_valid;
    assign o_out.done_res     = res.done_res;
    assign o_out.rearm        = res.rearm;
    assign o_out.sample_count = res.sample_count;
    assign o_out.average_ns   = res.average_ns;
    assign o_out.variance_est = res.variance_est;
    assign o_out.minimum_ns   = res.minimum_ns;
    assign o_out.maximum_ns   = res.maximum_ns;

endmodule

### src/lst_checker.sv
// ----------------------------------------------------------------------------
// lst_checker - port-level checks for the latency statistics tracker
// Watches the channels only; bound to the top level below.
// ----------------------------------------------------------------------------
module lst_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input logic          i_done_res,
    input logic          i_rearm,
    input lst_pkg::t_lat i_minimum_ns,
    input lst_pkg::t_lat i_maximum_ns
);

    logic [lst_pkg::OUTST_W-1:0] r_outst;
    logic [lst_pkg::OUTST_W-1:0] n_outst;
    logic                        in_acc;
    logic                        out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_comb begin
        n_outst = r_outst;
        if (in_acc && !out_acc) begin
            n_outst = r_outst + lst_pkg::OUTST_W'(1);
        end else if (out_acc && !in_acc) begin
            n_outst = r_outst - lst_pkg::OUTST_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst <= '0;
        end else begin
            r_outst <= n_outst;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_done_xor_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_done_res != i_rearm))
        else $error("done and rearm not exclusive");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_maximum_ns != '0) |-> (i_minimum_ns <= i_maximum_ns))
        else $error("minimum above maximum");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_outst != '0))
        else $error("result word without a tick word");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outst <= lst_pkg::OUTST_W'(lst_pkg::PIPE_WORDS))
        else $error("more words in flight than pipe slots");

endmodule

bind latency_statistics_tracker lst_checker u_lst_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_done_res   (o_out.done_res),
    .i_rearm      (o_out.rearm),
    .i_minimum_ns (o_out.minimum_ns),
    .i_maximum_ns (o_out.maximum_ns)
);

### verif/latency_statistics_tracker_tb.sv
// ----------------------------------------------------------------------------
// latency_statistics_tracker_tb - self-checking bench for the latency tracker
// Sends tick words through the input channel under random idling and one long
// output hold-off. A local mirror of the tracker's count, average, variance,
// min and max predicts every statistics word, and each one is checked field
// by field. The sample target is rewritten between phases, and the run ends
// with the count driven up to a nearby target and then on past a lowered one.
// ----------------------------------------------------------------------------
module latency_statistics_tracker_tb;

    localparam int            CYCLE_LIMIT  = 200_000;
    localparam int            DRAIN_CYCLES = 12;       // pipe is 4 deep, plus margin
    localparam int            HOLD_CYCLES  = 80;       // long output hold-off
    localparam int            RAND_PHASES  = 8;
    localparam int            PHASE_WORDS  = 125;
    localparam lst_pkg::t_lat LAT_TOP      = 30'd999_999_999;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_wr_en;
    lst_pkg::t_cnt i_cfg_wr_data;

    lst_in_if  in_ch ();
    lst_out_if out_ch ();

    latency_statistics_tracker u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    // ------------------------------------------------------------------
    // Mirror of the tracker state, moved on every accepted tick word.
    // ------------------------------------------------------------------
    lst_pkg::t_cnt trk_target = '0;
    lst_pkg::t_cnt trk_count  = '0;
    lst_pkg::t_lat trk_avg    = '0;
    lst_pkg::t_var trk_var    = '0;
    lst_pkg::t_lat trk_min    = lst_pkg::LAT_ONES;
    lst_pkg::t_lat trk_max    = '0;

    lst_pkg::t_in_word tick_backlog [$];   // words waiting for the driver
    lst_pkg::t_result  stats_due [$];      // predicted statistics words, oldest first

    int mismatches = 0;

    // Idling controls, set by the sequence between phases.
    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;
    int tx_gap      = 0;
    int rx_gap      = 0;

    // Long hold-off on the output side: requested once, counted on its own.
    bit stall_req   = 1'b0;
    bit hold_used   = 1'b0;
    int hold_left   = 0;

    task automatic log_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("%0t mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Advance the mirror by one tick and queue the word it must produce.
    task automatic track_tick(input logic seen, input lst_pkg::t_lat s);
        lst_pkg::t_result r;
        logic [30:0]      pair;
        lst_pkg::t_lat    err_mag;
        logic [59:0]      sq;
        logic [63:0]      vsum;

        r = '0;
        if (trk_count == trk_target) begin
            // target met: report only, state frozen, no rearm
            r.done_res = 1'b1;
        end else begin
            r.rearm = 1'b1;
            if (seen) begin
                trk_count = trk_count + 1'b1;   // wraps at 16 bits
                if (trk_avg == '0) begin
                    trk_avg = s;                // zero average takes the sample as is
                end else begin
                    pair    = {1'b0, s} + {1'b0, trk_avg};
                    trk_avg = pair[30:1];
                end
                // |avg - s| squared; the sign drops out
                err_mag = (trk_avg >= s) ? trk_avg - s : s - trk_avg;
                sq      = {30'd0, err_mag} * {30'd0, err_mag};
                vsum    = {32'd0, trk_var} + {4'd0, sq};
                trk_var = vsum[32:1];
                if (s < trk_min) trk_min = s;
                if (s > trk_max) trk_max = s;
            end
        end
        r.sample_count = trk_count;
        r.average_ns   = trk_avg;
        r.variance_est = trk_var;
        r.minimum_ns   = trk_min;
        r.maximum_ns   = trk_max;
        stats_due.push_back(r);
    endtask

    // Latency mix: full 30-bit noise, small values, the extremes, zero, and,
    // half the time, plain in-range values.
    function automatic lst_pkg::t_lat pick_latency();
        case ($urandom_range(0, 7))
            0: return lst_pkg::t_lat'($urandom);
            1: return lst_pkg::t_lat'($urandom_range(0, 2000));
            2: return ($urandom_range(0, 1) != 0) ? LAT_TOP : lst_pkg::LAT_ONES;
            3: return '0;
            default: return lst_pkg::t_lat'($urandom_range(0, 999_999_999));
        endcase
    endfunction

    task automatic queue_tick(input logic seen, input lst_pkg::t_lat lat);
        lst_pkg::t_in_word w;
        w.edge_seen  = seen;
        w.latency_ns = lat;
        tick_backlog.push_back(w);
    endtask

    // Target writes only happen with the pipe empty (see settle_pipe).
    task automatic write_target(input lst_pkg::t_cnt value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        trk_target = value;
        @(negedge i_clk);
    endtask

    // Wait until every word is sent and every prediction is met, then let
    // the pipe drain.
    task automatic settle_pipe();
        do
            @(negedge i_clk);
        while (tick_backlog.size() != 0 || in_ch.valid || stats_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Driver: presents the backlog one word at a time, with random gaps.
    // A word is taken on a rising edge with valid and ready both high.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        lst_pkg::t_in_word w;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                track_tick(in_ch.edge_seen, in_ch.latency_ns);
            // a held word stays put until it is taken
            if (!in_ch.valid || in_ch.ready) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    in_ch.valid <= 1'b0;
                end else if (tick_backlog.size() != 0 && tx_idle_on
                             && $urandom_range(0, 5) == 0) begin
                    // burst of idle cycles of random length, this one included
                    tx_gap = $urandom_range(0, 12);
                    in_ch.valid <= 1'b0;
                end else if (tick_backlog.size() != 0) begin
                    w = tick_backlog.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.edge_seen  <= w.edge_seen;
                    in_ch.latency_ns <= w.latency_ns;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Hold-off counter: one long stall of the output side on request.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_req && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each statistics word against the oldest prediction
    // and throttles ready in bursts.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        lst_pkg::t_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (stats_due.size() == 0) begin
                    log_mismatch("word with nothing expected, sample_count",
                                 out_ch.sample_count, 0);
                end else begin
                    want = stats_due.pop_front();
                    if (out_ch.done_res !== want.done_res)
                        log_mismatch("done_res", out_ch.done_res, want.done_res);
                    if (out_ch.rearm !== want.rearm)
                        log_mismatch("rearm", out_ch.rearm, want.rearm);
                    if (out_ch.sample_count !== want.sample_count)
                        log_mismatch("sample_count", out_ch.sample_count, want.sample_count);
                    if (out_ch.average_ns !== want.average_ns)
                        log_mismatch("average_ns", out_ch.average_ns, want.average_ns);
                    if (out_ch.variance_est !== want.variance_est)
                        log_mismatch("variance_est", out_ch.variance_est, want.variance_est);
                    if (out_ch.minimum_ns !== want.minimum_ns)
                        log_mismatch("minimum_ns", out_ch.minimum_ns, want.minimum_ns);
                    if (out_ch.maximum_ns !== want.maximum_ns)
                        log_mismatch("maximum_ns", out_ch.maximum_ns, want.maximum_ns);
                end
            end
            if (rx_gap != 0) begin
                rx_gap--;
                out_ch.ready <= 1'b0;
            end else if (hold_left != 0) begin
                out_ch.ready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                rx_gap = $urandom_range(0, 12);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Run limit
    // ------------------------------------------------------------------
    initial begin
        int cyc;
        cyc = 0;
        while (cyc < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("latency_statistics_tracker_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        lst_pkg::t_cnt next_target;
        int            n_words;

        i_rst_n          = 1'b0;
        i_cfg_wr_en      = 1'b0;
        i_cfg_wr_data    = '0;
        in_ch.valid      = 1'b0;
        in_ch.edge_seen  = 1'b0;
        in_ch.latency_ns = '0;
        out_ch.ready     = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset target is 0 and the count is 0: done from the first tick,
        // whatever the word holds.
        queue_tick(1'b1, lst_pkg::LAT_ONES);
        queue_tick(1'b0, '0);
        queue_tick(1'b1, LAT_TOP);
        settle_pipe();

        // Directed: missed edge, zero samples (average stays zero and the
        // next sample is taken as is), out-of-range and extreme latencies,
        // alternating bit patterns, then done once eight samples are in.
        write_target(16'd8);
        queue_tick(1'b0, lst_pkg::LAT_ONES);
        queue_tick(1'b1, '0);
        queue_tick(1'b1, '0);
        queue_tick(1'b1, 30'd5);
        queue_tick(1'b1, lst_pkg::LAT_ONES);
        queue_tick(1'b1, LAT_TOP);
        queue_tick(1'b1, 30'd1);
        queue_tick(1'b0, 30'd12345);
        queue_tick(1'b1, 30'h2AAA_AAAA);
        queue_tick(1'b1, 30'h1555_5555);
        queue_tick(1'b1, 30'd7);
        queue_tick(1'b0, '0);
        settle_pipe();

        // Random phases, each with its own target, mostly relative to the count.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0:       next_target = '0;                      // below the count
                3:       next_target = lst_pkg::t_cnt'($urandom_range(0, 65535));
                5:       next_target = trk_count + 16'd100;
                6:       next_target = trk_count - 1'b1;        // just below
                default: next_target = trk_count + lst_pkg::t_cnt'($urandom_range(1, 110));
            endcase
            write_target(next_target);

            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if (ph == 2) begin
                // a stretch with no idling at all
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if (ph == 5) begin
                // sender keeps offering while the output is held: pipe fills
                tx_idle_on = 1'b0;
                stall_req  = 1'b1;
            end

            for (int k = 0; k < PHASE_WORDS; k++)
                queue_tick($urandom_range(0, 9) != 0, pick_latency());
            settle_pipe();
        end

        // Last part, no idling: climb to a nearby target and stop there, then
        // lower the target below the count so counting goes on past it.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_target(trk_count + 16'd30);
        n_words = 34;
        for (int k = 0; k < n_words; k++)
            queue_tick(1'b1, pick_latency());
        settle_pipe();

        write_target(16'd5);
        for (int k = 0; k < 10; k++)
            queue_tick(1'b1, pick_latency());
        settle_pipe();

        if (mismatches == 0)
            $display("latency_statistics_tracker_tb passed");
        else
            $display("latency_statistics_tracker_tb failed");
        $finish;
    end

endmodule

### files.f
src/lst_pkg.sv
src/lst_if.sv
src/lst_skid.sv
src/lst_front.sv
src/lst_back.sv
src/latency_statistics_tracker.sv
src/lst_checker.sv
verif/latency_statistics_tracker_tb.sv
